### src/qnl_pkg.sv
// Shared types, constants and step functions for the quaternion nlerp pipeline.
// No dependencies.
package qnl_pkg;

    localparam int NumLanes  = 4;
    localparam int SqrtSteps = 32;
    localparam int QuoBits   = 17;

    localparam logic [16:0] OneQ16       = 17'd65536;
    localparam logic [62:0] ZeroLenLimit = 63'd115;
    localparam logic [31:0] UnitLen      = 32'h4000_0000;
    localparam logic [16:0] PosCap       = 17'd32767;
    localparam logic [16:0] NegCap       = 17'd32768;

    typedef struct packed {
        logic signed [15:0] from_x;
        logic signed [15:0] from_y;
        logic signed [15:0] from_z;
        logic signed [15:0] from_w;
        logic signed [15:0] to_x;
        logic signed [15:0] to_y;
        logic signed [15:0] to_z;
        logic signed [15:0] to_w;
        logic        [16:0] blend_weight;
    } t_in;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic signed [15:0] out_w;
        logic               zero_length;
    } t_out;

    // blended components, Q1.30, one 32-bit field per lane
    typedef logic [NumLanes-1:0][31:0] t_pvec;

    typedef struct packed {
        logic [62:0] s;
        logic [62:0] res;
    } t_sqrt;

    typedef struct packed {
        logic [49:0] rem;
        logic [16:0] q;
    } t_div;

    // one digit of the shift-subtract square root, bit weight 4^k
    function automatic t_sqrt sqrt_step(t_sqrt x, int k);
        t_sqrt       y;
        logic [62:0] bw;
        logic [62:0] trial;
        bw    = 63'd1 << (2 * k);
        trial = x.res + bw;
        if (x.s >= trial) begin
            y.s   = x.s - trial;
            y.res = (x.res >> 1) + bw;
        end else begin
            y.s   = x.s;
            y.res = x.res >> 1;
        end
        return y;
    endfunction

    // one quotient bit of restoring division
    function automatic t_div div_step(t_div x, logic [32:0] d, int k);
        t_div        y;
        logic [49:0] sh;
        sh = {17'd0, d} << k;
        y  = x;
        if (x.rem >= sh) begin
            y.rem  = x.rem - sh;
            y.q[k] = 1'b1;
        end
        return y;
    endfunction

endpackage

### src/qnl_front.sv
// Front stages: dot product and sign fix, lerp, squares, sum of squares.
// Depends on qnl_pkg.
module qnl_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  qnl_pkg::t_in   i_data,
    output logic           o_valid,
    output qnl_pkg::t_pvec o_p,
    output logic [62:0]    o_s,
    output logic           o_zero
);
    import qnl_pkg::*;

    logic signed [15:0] a [NumLanes];
    logic signed [15:0] b [NumLanes];
    logic signed [33:0] dot;
    logic        [16:0] tc;

    logic               r1_v;
    logic signed [15:0] r1_a [NumLanes];
    logic signed [15:0] r1_b [NumLanes];
    logic        [16:0] r1_t;
    logic               r1_neg;

    t_pvec              n2_p;
    logic               r2_v;
    t_pvec              r2_p;

    logic        [61:0] n3_sq [NumLanes];
    logic               r3_v;
    t_pvec              r3_p;
    logic        [61:0] r3_sq [NumLanes];

    logic        [62:0] n4_s;
    logic               r4_v;
    t_pvec              r4_p;
    logic        [62:0] r4_s;
    logic               r4_zero;

    always_comb begin
        a[0] = i_data.from_x;
        a[1] = i_data.from_y;
        a[2] = i_data.from_z;
        a[3] = i_data.from_w;
        b[0] = i_data.to_x;
        b[1] = i_data.to_y;
        b[2] = i_data.to_z;
        b[3] = i_data.to_w;
        tc   = (i_data.blend_weight > OneQ16) ? OneQ16 : i_data.blend_weight;
        dot  = '0;
        for (int i = 0; i < NumLanes; i++) begin
            dot = dot + 34'(a[i] * b[i]);
        end
    end

    // lerp: r31 = a*2^16 + (b' - a)*t, then round to Q1.30 (half up)
    always_comb begin
        logic signed [16:0] bn;
        logic signed [17:0] diff;
        logic signed [35:0] prod;
        logic signed [36:0] r31;
        for (int i = 0; i < NumLanes; i++) begin
            bn   = r1_neg ? -17'(r1_b[i]) : 17'(r1_b[i]);
            diff = 18'(bn) - 18'(r1_a[i]);
            prod = diff * $signed({1'b0, r1_t});
            r31  = ($signed(37'(r1_a[i])) <<< 16) + 37'(prod) + 37'sd1;
            n2_p[i] = r31[32:1];
        end
    end

    always_comb begin
        logic signed [63:0] sq;
        for (int i = 0; i < NumLanes; i++) begin
            sq       = $signed(r2_p[i]) * $signed(r2_p[i]);
            n3_sq[i] = sq[61:0];
        end
    end

    always_comb begin
        n4_s = '0;
        for (int i = 0; i < NumLanes; i++) begin
            n4_s = n4_s + 63'(r3_sq[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < NumLanes; i++) begin
                r1_a[i]  <= a[i];
                r1_b[i]  <= b[i];
                r3_sq[i] <= n3_sq[i];
            end
            r1_t    <= tc;
            r1_neg  <= dot[33];
            r2_p    <= n2_p;
            r3_p    <= r2_p;
            r4_p    <= r3_p;
            r4_s    <= n4_s;
            r4_zero <= (n4_s <= ZeroLenLimit);
        end
    end

    assign o_valid = r4_v;
    assign o_p     = r4_p;
    assign o_s     = r4_s;
    assign o_zero  = r4_zero;

endmodule

### src/qnl_sqrt.sv
// Integer square root of the sum of squares, one result bit per stage.
// Depends on qnl_pkg.
module qnl_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  qnl_pkg::t_pvec i_p,
    input  logic [62:0]    i_s,
    input  logic           i_zero,
    output logic           o_valid,
    output qnl_pkg::t_pvec o_p,
    output logic [31:0]    o_len,
    output logic           o_zero
);
    import qnl_pkg::*;

    logic  r_v    [1:SqrtSteps];
    t_sqrt r_st   [1:SqrtSteps];
    t_pvec r_p    [1:SqrtSteps];
    logic  r_zero [1:SqrtSteps];

    for (genvar j = 0; j < SqrtSteps; j++) begin : g_stage
        localparam int K = SqrtSteps - 1 - j;
        t_sqrt cur;
        logic  cur_v;
        t_pvec cur_p;
        logic  cur_zero;
        if (j == 0) begin : g_head
            assign cur.s    = i_s;
            assign cur.res  = '0;
            assign cur_v    = i_valid;
            assign cur_p    = i_p;
            assign cur_zero = i_zero;
        end else begin : g_body
            assign cur      = r_st[j];
            assign cur_v    = r_v[j];
            assign cur_p    = r_p[j];
            assign cur_zero = r_zero[j];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_adv) begin
                r_v[j+1] <= cur_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_st[j+1]   <= sqrt_step(cur, K);
                r_p[j+1]    <= cur_p;
                r_zero[j+1] <= cur_zero;
            end
        end
    end

    assign o_valid = r_v[SqrtSteps];
    assign o_p     = r_p[SqrtSteps];
    assign o_len   = r_st[SqrtSteps].res[31:0];
    assign o_zero  = r_zero[SqrtSteps];

endmodule

### src/qnl_div.sv
// Per-lane rounded division p*2^15/len by restoring long division, then saturation.
// Depends on qnl_pkg.
module qnl_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  qnl_pkg::t_pvec i_p,
    input  logic [31:0]    i_len,
    input  logic           i_zero,
    output logic           o_valid,
    output qnl_pkg::t_out  o_data
);
    import qnl_pkg::*;

    logic                r_v    [0:QuoBits];
    logic [32:0]         r_d    [0:QuoBits];
    logic                r_zero [0:QuoBits];
    logic [NumLanes-1:0] r_neg  [0:QuoBits];
    logic [NumLanes-1:0] r_ovf  [0:QuoBits];
    t_div                r_dv   [0:QuoBits][NumLanes];

    logic [31:0]         n0_len;
    logic [32:0]         n0_d;
    logic [NumLanes-1:0] n0_neg;
    logic [NumLanes-1:0] n0_ovf;
    t_div                n0_dv  [NumLanes];

    logic                r_ov;
    t_out                r_out;
    logic [15:0]         n_res [NumLanes];

    // numerator |p|*2^16 + len over 2*len gives round-half-away of p*2^15/len;
    // a zero-length blend divides by 2^30 instead, i.e. plain rounding to Q1.15
    always_comb begin
        logic [31:0] mag;
        logic [49:0] num;
        n0_len = i_zero ? UnitLen : i_len;
        n0_d   = {n0_len, 1'b0};
        for (int i = 0; i < NumLanes; i++) begin
            n0_neg[i]    = i_p[i][31];
            mag          = n0_neg[i] ? -i_p[i] : i_p[i];
            num          = {2'd0, mag, 16'd0} + 50'(n0_len);
            n0_ovf[i]    = (num >= {n0_d, 17'd0});
            n0_dv[i].rem = num;
            n0_dv[i].q   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d[0]    <= n0_d;
            r_zero[0] <= i_zero;
            r_neg[0]  <= n0_neg;
            r_ovf[0]  <= n0_ovf;
            for (int i = 0; i < NumLanes; i++) begin
                r_dv[0][i] <= n0_dv[i];
            end
        end
    end

    for (genvar j = 1; j <= QuoBits; j++) begin : g_stage
        localparam int K = QuoBits - j;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_adv) begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_d[j]    <= r_d[j-1];
                r_zero[j] <= r_zero[j-1];
                r_neg[j]  <= r_neg[j-1];
                r_ovf[j]  <= r_ovf[j-1];
                for (int i = 0; i < NumLanes; i++) begin
                    r_dv[j][i] <= div_step(r_dv[j-1][i], r_d[j-1], K);
                end
            end
        end
    end

    always_comb begin
        logic [16:0] q;
        logic [16:0] m;
        for (int i = 0; i < NumLanes; i++) begin
            q = r_dv[QuoBits][i].q;
            if (r_neg[QuoBits][i]) begin
                m        = (r_ovf[QuoBits][i] || q > NegCap) ? NegCap : q;
                n_res[i] = 16'(-m);
            end else begin
                m        = (r_ovf[QuoBits][i] || q > PosCap) ? PosCap : q;
                n_res[i] = m[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_adv) begin
            r_ov <= r_v[QuoBits];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_out.out_x       <= n_res[0];
            r_out.out_y       <= n_res[1];
            r_out.out_z       <= n_res[2];
            r_out.out_w       <= n_res[3];
            r_out.zero_length <= r_zero[QuoBits];
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

### src/quaternion_nlerp.sv
// Quaternion nlerp, fully pipelined: a request enters every cycle while not stalled.
// 4 front stages + 32 square-root stages + 18 divider stages + 1 output register lie
// between a request's acceptance and its result being presented.
// Throughput is one request per cycle; a downstream stall freezes all stages.
// Reset (synchronous, active low) clears every stage valid bit; data is not reset.
module quaternion_nlerp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  qnl_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output qnl_pkg::t_out o_data
);
    import qnl_pkg::*;

    logic        adv;
    logic        f_v;
    t_pvec       f_p;
    logic [62:0] f_s;
    logic        f_zero;
    logic        q_v;
    t_pvec       q_p;
    logic [31:0] q_len;
    logic        q_zero;

    // whole pipeline moves unless the held result is not taken
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    qnl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (f_v),
        .o_p     (f_p),
        .o_s     (f_s),
        .o_zero  (f_zero)
    );

    qnl_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (f_v),
        .i_p     (f_p),
        .i_s     (f_s),
        .i_zero  (f_zero),
        .o_valid (q_v),
        .o_p     (q_p),
        .o_len   (q_len),
        .o_zero  (q_zero)
    );

    qnl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (q_v),
        .i_p     (q_p),
        .i_len   (q_len),
        .i_zero  (q_zero),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

`ifndef SYNTHESIS
    // a blend too short to normalize rounds to all zeros
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.zero_length |->
            o_data.out_x == 16'd0 && o_data.out_y == 16'd0 &&
            o_data.out_z == 16'd0 && o_data.out_w == 16'd0)
        else $error("zero-length result has nonzero component");

    // a normalized result has unit length, so it cannot be all zeros
    a_unit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.zero_length |->
            o_data.out_x != 16'd0 || o_data.out_y != 16'd0 ||
            o_data.out_z != 16'd0 || o_data.out_w != 16'd0)
        else $error("normalized result is all zeros");

    // a result held under an output stall must stay valid and unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_data) && o_valid)
        else $error("held result changed under stall");
`endif

endmodule

### sim/nlerp_checker.sv
// Checker for quaternion_nlerp: watches both channels, predicts each result
// from the accepted request, and compares. Depends on qnl_pkg.
module nlerp_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_stall_up,
    input  qnl_pkg::t_in   i_data,
    input  logic           i_res_valid,
    input  logic           i_res_stall,
    input  qnl_pkg::t_out  i_res,
    output int             o_errors,
    output int             o_pending,
    output int             o_zero_seen
);
    import qnl_pkg::*;

    t_out blend_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // round half away from zero, then clamp to Q1.15
    function automatic logic [15:0] round_clamp(longint num, longint den);
        longint m;
        longint q;
        m = (num < 0) ? -num : num;
        q = (m * 2 + den) / (den * 2);
        if (num < 0) q = -q;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic t_out predict_nlerp(t_in d);
        longint a[4];
        longint b[4];
        longint p[4];
        longint dot;
        longint t;
        longint r31;
        longint unsigned s;
        longint unsigned len;
        logic [15:0] o[4];
        t_out y;
        a = '{d.from_x, d.from_y, d.from_z, d.from_w};
        b = '{d.to_x, d.to_y, d.to_z, d.to_w};
        t = (d.blend_weight > 17'd65536) ? 65536 : longint'(d.blend_weight);
        dot = 0;
        for (int i = 0; i < 4; i++) dot += a[i] * b[i];
        if (dot < 0)
            for (int i = 0; i < 4; i++) b[i] = -b[i];
        s = 0;
        for (int i = 0; i < 4; i++) begin
            r31 = a[i] * 65536 + (b[i] - a[i]) * t + 1;
            p[i] = (r31 >= 0) ? r31 / 2 : -((-r31 + 1) / 2);
            s += longint'(p[i] * p[i]);
        end
        if (s <= 115) begin
            for (int i = 0; i < 4; i++) o[i] = round_clamp(p[i], 32768);
            y.zero_length = 1'b1;
        end else begin
            len = int_sqrt(s);
            for (int i = 0; i < 4; i++) o[i] = round_clamp(p[i] * 32768, longint'(len));
            y.zero_length = 1'b0;
        end
        y.out_x = o[0];
        y.out_y = o[1];
        y.out_z = o[2];
        y.out_w = o[3];
        return y;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        o_errors++;
    endtask

    assign o_pending = blend_q.size();

    initial begin
        o_errors = 0;
        o_zero_seen = 0;
    end

    always @(posedge i_clk) begin
        t_out w;
        if (i_rst_n && i_res_valid && !i_res_stall) begin
            if (blend_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                w = blend_q.pop_front();
                if (w.zero_length) o_zero_seen++;
                if (i_res.out_x !== w.out_x) report_mismatch("out_x", i_res.out_x, w.out_x);
                if (i_res.out_y !== w.out_y) report_mismatch("out_y", i_res.out_y, w.out_y);
                if (i_res.out_z !== w.out_z) report_mismatch("out_z", i_res.out_z, w.out_z);
                if (i_res.out_w !== w.out_w) report_mismatch("out_w", i_res.out_w, w.out_w);
                if (i_res.zero_length !== w.zero_length)
                    report_mismatch("zero_length", i_res.zero_length, w.zero_length);
            end
        end
        if (i_rst_n && i_valid && !i_stall_up)
            blend_q.insert(blend_q.size(), predict_nlerp(i_data));
    end
endmodule

### sim/tb_quaternion_nlerp.sv
// Testbench top for quaternion_nlerp: directed and random requests with random
// gaps and stalls on both sides. Depends on qnl_pkg, quaternion_nlerp, nlerp_checker.
module tb_quaternion_nlerp;
    import qnl_pkg::*;

    localparam int NumRandom = 700;
    localparam int Latency   = 55;
    localparam int IdleLimit = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    t_in  i_data = '0;
    t_out o_data;

    int errors;
    int pending;
    int zero_seen;
    int idle_cycles = 0;
    int sent = 0;
    bit hold_long = 1'b0;

    quaternion_nlerp uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    nlerp_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_up(o_stall),
        .i_data(i_data), .i_res_valid(o_valid), .i_res_stall(i_stall), .i_res(o_data),
        .o_errors(errors), .o_pending(pending), .o_zero_seen(zero_seen)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_comp();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(signed'($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in rand_request();
        t_in d;
        int k;
        d.from_x = pick_comp();
        d.from_y = pick_comp();
        d.from_z = pick_comp();
        d.from_w = pick_comp();
        k = $urandom_range(0, 9);
        if (k == 0) begin
            // opposite quaternions: the negative dot product makes the sign fix flip the target back toward the start
            d.to_x = -d.from_x;
            d.to_y = -d.from_y;
            d.to_z = -d.from_z;
            d.to_w = -d.from_w;
        end else if (k == 1) begin
            {d.to_x, d.to_y, d.to_z, d.to_w} = {d.from_x, d.from_y, d.from_z, d.from_w};
        end else begin
            d.to_x = pick_comp();
            d.to_y = pick_comp();
            d.to_z = pick_comp();
            d.to_w = pick_comp();
        end
        case ($urandom_range(0, 5))
            0: d.blend_weight = 17'd0;
            1: d.blend_weight = 17'd65536;
            2: d.blend_weight = 17'd32768;
            3: d.blend_weight = 17'($urandom_range(65537, 131071));
            default: d.blend_weight = 17'($urandom_range(0, 65536));
        endcase
        return d;
    endfunction

    // offers one request and waits until it is taken
    task automatic send_request(t_in d);
        i_valid <= 1'b1;
        i_data  <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_with_gap(t_in d);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            i_data  <= rand_request();
            repeat (g) @(posedge i_clk);
        end
        send_request(d);
    endtask

    function automatic t_in make_req(logic [15:0] fx, logic [15:0] fy, logic [15:0] fz,
                                     logic [15:0] fw, logic [15:0] tx, logic [15:0] ty,
                                     logic [15:0] tz, logic [15:0] tw, logic [16:0] bw);
        t_in d;
        d = '{fx, fy, fz, fw, tx, ty, tz, tw, bw};
        return d;
    endfunction

    // receiver side: random stalls, with one long hold-off while requests flow
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_long) begin
            i_stall <= hold_long;
        end else if (sent > 100 && sent < 300) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 25);
        end
    end

    initial begin
        @(posedge i_clk);
        wait (sent == 400);
        hold_long = 1'b1;
        repeat (200) @(posedge i_clk);
        hold_long = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("watchdog expired, %0d requests still outstanding", pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int n;
        t_in d;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // extremes, weight ends, opposite sign, saturation and zero length
        send_request(make_req(16'h7fff, 16'h0, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h0, 16'h0,
                              17'd0));
        send_request(make_req(16'h7fff, 16'h0, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h0, 16'h0,
                              17'd65536));
        send_request(make_req(16'h7fff, 16'h0, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h0, 16'h0,
                              17'd32768));
        send_request(make_req(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                              16'h7fff, 16'h7fff, 17'd32768));
        send_request(make_req(16'h8000, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h0,
                              17'd65536));
        send_request(make_req(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 17'd0));
        send_request(make_req(16'h1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 17'd0));
        send_request(make_req(16'h1, 16'hffff, 16'h1, 16'h0, 16'h0, 16'h1, 16'h0, 16'h0,
                              17'd32768));
        send_request(make_req(16'h4000, 16'h0, 16'h0, 16'h0, 16'hc000, 16'h0, 16'h0, 16'h0,
                              17'd32768));
        send_request(make_req(16'h1000, 16'h2000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h3000,
                              16'h0, 17'h1ffff));
        send_request(make_req(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                              16'h7fff, 16'h7fff, 17'd1));
        send_request(make_req(16'h0, 16'h0, 16'h0, 16'h5, 16'h0, 16'h0, 16'h0, 16'hfffb,
                              17'd32768));
        send_request(make_req(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0, 16'h0, 16'h0,
                              16'h0, 17'd65535));
        for (n = 0; n < NumRandom; n++) begin
            d = rand_request();
            if (sent >= 100 && sent < 300) send_request(d);
            else send_with_gap(d);
        end
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (Latency + 10) @(posedge i_clk);
        $display("sent %0d requests, %0d of them with a zero-length blend", sent, zero_seen);
        $display("covered component extremes, weight saturation, sign flip and stalls");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
